@@ rtl/lcdseq_pkg.sv @@
`default_nettype none
package lcdseq_pkg;

    localparam int DEF_PANEL_WIDTH  = 128;
    localparam int DEF_PANEL_HEIGHT = 160;

    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_BITS  = GLYPH_COLS * GLYPH_ROWS;
    localparam int GLYPH_COUNT = 95;

    localparam int IN_DATA_W  = 72;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_USER_W = 3;

    // Request codes.
    localparam logic [1:0] FUNC_PULL  = 2'd0;
    localparam logic [1:0] FUNC_FILL  = 2'd1;
    localparam logic [1:0] FUNC_PIXEL = 2'd2;
    localparam logic [1:0] FUNC_CHAR  = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_BYTE   = 2'd1;
    localparam logic [1:0] KIND_ACCEPT = 2'd2;
    localparam logic [1:0] KIND_BUSY   = 2'd3;

    // Display command bytes.
    localparam logic [7:0] CMD_CASET = 8'h2A;
    localparam logic [7:0] CMD_RASET = 8'h2B;
    localparam logic [7:0] CMD_RAMWR = 8'h2C;

    localparam logic [7:0] CHAR_FIRST = 8'h20;
    localparam logic [7:0] CHAR_LAST  = 8'h7E;

    // One glyph per entry, column 0 in the top byte; bit 6 of a column is the top row.
    localparam logic [39:0] FONT_ROM [GLYPH_COUNT] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
        40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h08082A1C08
    };

endpackage
`default_nettype wire

@@ rtl/lcd_draw_command_sequencer.sv @@
`default_nettype none
// Draw-command sequencer for an SPI colour panel: a transfer on the input stream carries either a
// draw command (fill rectangle, single pixel, 5x7 character) or a pull request, and every input
// transfer yields exactly one result transfer two register stages later (input register, then the
// result register). A pull returns the next byte of the panel's command stream with its data/command
// level and a tlast flag on the final byte of the draw, or a none result when idle; a command
// returns accepted or busy. One item is taken every clock cycle as long as the result side keeps
// taking results; the glyph lookup sits in front of the input register and the glyph position
// search after it, so no item iterates. Rows are flipped against the panel height with 8-bit wrap.
module lcd_draw_command_sequencer
    import lcdseq_pkg::*;
#(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // x_start[7:0], y_start[15:8], x_end[23:16], y_end[31:24],
    // fore_colour[47:32], back_colour[63:48], char_code[71:64]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // func[1:0]
    input  wire logic [IN_USER_W-1:0]  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // byte_value[7:0]
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // kind[1:0], is_data[2]
    output logic [OUT_USER_W-1:0]      m_tuser,
    output logic                       m_tlast
);

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_FILL_HDR  = 5'b00010,
        PH_FILL_DATA = 5'b00100,
        PH_CHAR_HDR  = 5'b01000,
        PH_CHAR_DATA = 5'b10000
    } phase_t;

    localparam logic [3:0] HS_CASET  = 4'd0;
    localparam logic [3:0] HS_COL_LO = 4'd2;
    localparam logic [3:0] HS_COL_HI = 4'd4;
    localparam logic [3:0] HS_RASET  = 4'd5;
    localparam logic [3:0] HS_ROW_LO = 4'd7;
    localparam logic [3:0] HS_ROW_HI = 4'd9;
    localparam logic [3:0] HS_RAMWR  = 4'd10;

    localparam logic [7:0] PW     = 8'(PANEL_WIDTH);
    localparam logic [7:0] PH     = 8'(PANEL_HEIGHT);
    localparam logic [7:0] PH_M1  = 8'(PANEL_HEIGHT - 1);
    localparam logic [7:0] ROW_TOP = 8'(GLYPH_ROWS - 1);

    // Input register.
    logic                  in_valid_reg;
    logic [1:0]            func_reg;
    logic [7:0]            x_start_reg, y_start_reg, x_end_reg, y_end_reg;
    logic [15:0]           fore_reg, back_reg;
    logic [39:0]           font_word_reg;

    // Sequencer state.
    phase_t                phase_reg, phase_next;
    logic [7:0]            win_col_lo_reg, win_col_lo_next;
    logic [7:0]            win_col_hi_reg, win_col_hi_next;
    logic [7:0]            win_row_lo_reg, win_row_lo_next;
    logic [7:0]            win_row_hi_reg, win_row_hi_next;
    logic [15:0]           ink_reg, ink_next;
    logic [15:0]           paper_reg, paper_next;
    logic [7:0]            col_counter_reg, col_counter_next;
    logic [7:0]            row_counter_reg, row_counter_next;
    logic [3:0]            header_step_reg, header_step_next;
    logic                  low_half_reg, low_half_next;
    logic [7:0]            origin_col_reg, origin_col_next;
    logic [7:0]            origin_row_reg, origin_row_next;
    logic [GLYPH_BITS-1:0] glyph_bits_reg, glyph_bits_next;
    logic [GLYPH_BITS-1:0] remain_reg, remain_next;
    logic                  cur_ink_reg, cur_ink_next;

    // Result register.
    logic                  out_valid_reg;
    logic [1:0]            kind_reg, kind_next;
    logic [7:0]            byte_reg, byte_next;
    logic                  is_data_reg, is_data_next;
    logic                  last_reg, last_next;

    logic                  advance;
    logic [7:0]            code_in;
    logic [6:0]            glyph_sel;

    logic                  busy, is_cmd;
    logic [7:0]            y1f, y2f, xa, xb, ya, yb, xlo, xhi, ylo, yhi;
    logic                  rect_on_panel;
    logic [GLYPH_BITS-1:0] cmd_bits, cmd_mask, seek_mask, seek_bits;
    logic [7:0]            seek_ox, seek_oy;
    logic [7:0]            xc [GLYPH_COLS];
    logic [7:0]            yr [GLYPH_ROWS];
    logic                  found, sel_bit, do_load;
    logic [7:0]            sel_x, sel_y;
    logic [15:0]           colour;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Glyph lookup ahead of the input register.
    assign code_in   = s_tdata[71:64];
    assign glyph_sel = (code_in < CHAR_FIRST || code_in > CHAR_LAST) ? 7'd0
                                                                     : 7'(code_in - CHAR_FIRST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            func_reg      <= s_tuser[1:0];
            x_start_reg   <= s_tdata[7:0];
            y_start_reg   <= s_tdata[15:8];
            x_end_reg     <= s_tdata[23:16];
            y_end_reg     <= s_tdata[31:24];
            fore_reg      <= s_tdata[47:32];
            back_reg      <= s_tdata[63:48];
            font_word_reg <= FONT_ROM[glyph_sel];
        end
    end

    assign busy   = (phase_reg == PH_FILL_HDR) || (phase_reg == PH_FILL_DATA) ||
                    (phase_reg == PH_CHAR_HDR) || (phase_reg == PH_CHAR_DATA);
    assign is_cmd = (func_reg != FUNC_PULL);

    // Rectangle corners: flip rows, collapse for a pixel, then order each pair.
    always_comb begin
        y1f = PH_M1 - y_start_reg;
        y2f = PH_M1 - y_end_reg;
        xa  = x_start_reg;
        ya  = y1f;
        xb  = (func_reg == FUNC_PIXEL) ? x_start_reg : x_end_reg;
        yb  = (func_reg == FUNC_PIXEL) ? y1f : y2f;
        xlo = (xa > xb) ? xb : xa;
        xhi = (xa > xb) ? xa : xb;
        ylo = (ya > yb) ? yb : ya;
        yhi = (ya > yb) ? ya : yb;
        rect_on_panel = (xlo < PW) && (ylo < PH);
    end

    // Glyph positions are numbered column-major: column c, row r sits at c*7+r.
    always_comb begin
        seek_ox = is_cmd ? x_start_reg : origin_col_reg;
        seek_oy = is_cmd ? y_start_reg : origin_row_reg;
        for (int c = 0; c < GLYPH_COLS; c++) begin
            xc[c] = seek_ox + 8'(c);
        end
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            yr[r] = PH_M1 - (seek_oy + ROW_TOP - 8'(r));
        end
        for (int c = 0; c < GLYPH_COLS; c++) begin
            for (int r = 0; r < GLYPH_ROWS; r++) begin
                cmd_bits[c*GLYPH_ROWS+r] = font_word_reg[8*(GLYPH_COLS-1-c) + (GLYPH_ROWS-1-r)];
                cmd_mask[c*GLYPH_ROWS+r] = (cmd_bits[c*GLYPH_ROWS+r] || (fore_reg != back_reg)) &&
                                           (xc[c] < PW) && (yr[r] < PH);
            end
        end
        seek_mask = is_cmd ? cmd_mask : remain_reg;
        seek_bits = is_cmd ? cmd_bits : glyph_bits_reg;
        // Walk from the far end so that the lowest set position wins.
        found   = 1'b0;
        sel_bit = 1'b0;
        sel_x   = 8'h00;
        sel_y   = 8'h00;
        for (int c = GLYPH_COLS - 1; c >= 0; c--) begin
            for (int r = GLYPH_ROWS - 1; r >= 0; r--) begin
                if (seek_mask[c*GLYPH_ROWS+r]) begin
                    found   = 1'b1;
                    sel_bit = seek_bits[c*GLYPH_ROWS+r];
                    sel_x   = xc[c];
                    sel_y   = yr[r];
                end
            end
        end
    end

    always_comb begin
        phase_next       = phase_reg;
        win_col_lo_next  = win_col_lo_reg;
        win_col_hi_next  = win_col_hi_reg;
        win_row_lo_next  = win_row_lo_reg;
        win_row_hi_next  = win_row_hi_reg;
        ink_next         = ink_reg;
        paper_next       = paper_reg;
        col_counter_next = col_counter_reg;
        row_counter_next = row_counter_reg;
        header_step_next = header_step_reg;
        low_half_next    = low_half_reg;
        origin_col_next  = origin_col_reg;
        origin_row_next  = origin_row_reg;
        glyph_bits_next  = glyph_bits_reg;
        remain_next      = remain_reg;
        cur_ink_next     = cur_ink_reg;
        kind_next        = KIND_NONE;
        byte_next        = 8'h00;
        is_data_next     = 1'b0;
        last_next        = 1'b0;
        do_load          = 1'b0;
        colour           = ink_reg;

        if (is_cmd) begin
            if (busy) begin
                kind_next = KIND_BUSY;
            end else begin
                kind_next = KIND_ACCEPT;
                ink_next  = fore_reg;
                if (func_reg == FUNC_CHAR) begin
                    paper_next      = back_reg;
                    origin_col_next = x_start_reg;
                    origin_row_next = y_start_reg;
                    glyph_bits_next = cmd_bits;
                    phase_next      = PH_IDLE;
                    do_load         = found;
                end else if (rect_on_panel) begin
                    win_col_lo_next  = xlo;
                    win_col_hi_next  = xhi;
                    win_row_lo_next  = ylo;
                    win_row_hi_next  = yhi;
                    col_counter_next = xlo;
                    row_counter_next = ylo;
                    header_step_next = HS_CASET;
                    low_half_next    = 1'b0;
                    phase_next       = PH_FILL_HDR;
                end
            end
        end else if (busy) begin
            kind_next = KIND_BYTE;
            case (phase_reg)
                PH_FILL_HDR, PH_CHAR_HDR: begin
                    case (header_step_reg)
                        HS_CASET:  byte_next = CMD_CASET;
                        HS_COL_LO: byte_next = win_col_lo_reg;
                        HS_COL_HI: byte_next = win_col_hi_reg;
                        HS_RASET:  byte_next = CMD_RASET;
                        HS_ROW_LO: byte_next = win_row_lo_reg;
                        HS_ROW_HI: byte_next = win_row_hi_reg;
                        HS_RAMWR:  byte_next = CMD_RAMWR;
                        default:   byte_next = 8'h00;
                    endcase
                    is_data_next = !((header_step_reg == HS_CASET) ||
                                     (header_step_reg == HS_RASET) ||
                                     (header_step_reg >= HS_RAMWR));
                    if (header_step_reg >= HS_RAMWR) begin
                        phase_next    = (phase_reg == PH_FILL_HDR) ? PH_FILL_DATA : PH_CHAR_DATA;
                        low_half_next = 1'b0;
                    end else begin
                        header_step_next = header_step_reg + 4'd1;
                    end
                end
                PH_FILL_DATA: begin
                    is_data_next = 1'b1;
                    byte_next    = low_half_reg ? ink_reg[7:0] : ink_reg[15:8];
                    if (!low_half_reg) begin
                        low_half_next = 1'b1;
                    end else begin
                        low_half_next = 1'b0;
                        if (col_counter_reg >= win_col_hi_reg) begin
                            if (row_counter_reg >= win_row_hi_reg) begin
                                last_next  = 1'b1;
                                phase_next = PH_IDLE;
                            end else begin
                                col_counter_next = win_col_lo_reg;
                                row_counter_next = row_counter_reg + 8'd1;
                            end
                        end else begin
                            col_counter_next = col_counter_reg + 8'd1;
                        end
                    end
                end
                PH_CHAR_DATA: begin
                    colour       = cur_ink_reg ? ink_reg : paper_reg;
                    is_data_next = 1'b1;
                    byte_next    = low_half_reg ? colour[7:0] : colour[15:8];
                    if (!low_half_reg) begin
                        low_half_next = 1'b1;
                    end else if (found) begin
                        do_load = 1'b1;
                    end else begin
                        last_next     = 1'b1;
                        low_half_next = 1'b0;
                        phase_next    = PH_IDLE;
                    end
                end
                default: begin
                    kind_next  = KIND_NONE;
                    phase_next = PH_IDLE;
                end
            endcase
        end else begin
            phase_next = PH_IDLE;
        end

        // Start the one-pixel window of the next drawn glyph position.
        if (do_load) begin
            win_col_lo_next  = sel_x;
            win_col_hi_next  = sel_x;
            win_row_lo_next  = sel_y;
            win_row_hi_next  = sel_y;
            cur_ink_next     = sel_bit;
            remain_next      = seek_mask & (seek_mask - GLYPH_BITS'(1));
            header_step_next = HS_CASET;
            low_half_next    = 1'b0;
            phase_next       = PH_CHAR_HDR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                phase_reg     <= phase_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (advance) begin
            win_col_lo_reg  <= win_col_lo_next;
            win_col_hi_reg  <= win_col_hi_next;
            win_row_lo_reg  <= win_row_lo_next;
            win_row_hi_reg  <= win_row_hi_next;
            ink_reg         <= ink_next;
            paper_reg       <= paper_next;
            col_counter_reg <= col_counter_next;
            row_counter_reg <= row_counter_next;
            header_step_reg <= header_step_next;
            low_half_reg    <= low_half_next;
            origin_col_reg  <= origin_col_next;
            origin_row_reg  <= origin_row_next;
            glyph_bits_reg  <= glyph_bits_next;
            remain_reg      <= remain_next;
            cur_ink_reg     <= cur_ink_next;
            kind_reg        <= kind_next;
            byte_reg        <= byte_next;
            is_data_reg     <= is_data_next;
            last_reg        <= last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = {is_data_reg, kind_reg};
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire

@@ rtl/lcdseq_checker.sv @@
`default_nettype none
module lcdseq_checker
    import lcdseq_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [IN_DATA_W-1:0]  s_tdata,
    input wire logic [IN_USER_W-1:0]  s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic [OUT_USER_W-1:0] m_tuser,
    input wire logic                  m_tlast
);

    // Only byte results carry a payload.
    a_quiet_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] != KIND_BYTE) |->
            (m_tdata == 8'h00) && !m_tuser[2] && !m_tlast)
        else $error("non-byte result carries payload");

    // The closing byte of a draw is always a colour data byte.
    a_last_is_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tuser[1:0] == KIND_BYTE) && m_tuser[2])
        else $error("tlast on a non-data byte");

    // With the result side empty the input side never stalls.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with no pending result");

    // A stalled result transfer holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                                  $stable(m_tlast))
        else $error("result changed while stalled");

endmodule

bind lcd_draw_command_sequencer lcdseq_checker u_lcdseq_checker (.*);
`default_nettype wire

@@ tb/lcd_draw_command_sequencer_tb.sv @@
`timescale 1ns / 100ps

module lcd_draw_command_sequencer_tb;
    import lcdseq_pkg::*;

    localparam int PANEL_W = DEF_PANEL_WIDTH;
    localparam int PANEL_H = DEF_PANEL_HEIGHT;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  x_start;
        logic [7:0]  y_start;
        logic [7:0]  x_end;
        logic [7:0]  y_end;
        logic [15:0] fore_colour;
        logic [15:0] back_colour;
        logic [7:0]  char_code;
    } draw_req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
        logic       is_data;
        logic       last;
    } panel_resp_t;

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_FILL_HDR  = 5'b00010,
        ST_FILL_DATA = 5'b00100,
        ST_CHAR_DATA = 5'b01000,
        ST_CHAR_HDR  = 5'b10000
    } seq_state_t;

    // Tracks the sequencer's state transfer by transfer and keeps the responses still owed.
    class panel_stream_scoreboard;
        panel_resp_t expected_responses[$];
        int          fails = 0;
        int          n_taken = 0;
        int          n_refused = 0;
        int          n_bytes = 0;
        int          n_draws = 0;

        seq_state_t  state = ST_IDLE;
        logic [7:0]  win_col_lo = 0, win_col_hi = 0, win_row_lo = 0, win_row_hi = 0;
        logic [15:0] ink = 0, paper = 0;
        logic [7:0]  col_ctr = 0, row_ctr = 0;
        logic [3:0]  hdr_step = 0;
        logic        low_half = 0;
        logic [2:0]  gcol = 0, grow = 0;
        logic [6:0]  glyph_idx = 0;
        logic [7:0]  origin_col = 0, origin_row = 0;

        function bit busy();
            return state != ST_IDLE;
        endfunction

        function int pending();
            return expected_responses.size();
        endfunction

        function logic [7:0] flip_row(logic [7:0] y);
            return 8'(PANEL_H - 1 - int'(y));
        endfunction

        function bit glyph_bit(int c, int r);
            int         g;
            logic [7:0] column;
            g = (glyph_idx < GLYPH_COUNT) ? int'(glyph_idx) : 0;
            column = FONT_ROM[g][(GLYPH_COLS - 1 - c) * 8 +: 8];
            return column[6 - r];
        endfunction

        function bit glyph_emits(int c, int r, output logic [7:0] px, output logic [7:0] py);
            logic [7:0] x, y;
            px = 0;
            py = 0;
            if (!glyph_bit(c, r) && ink == paper) return 0;
            x = 8'(int'(origin_col) + c);
            y = flip_row(8'(int'(origin_row) + 6 - r));
            if (x >= PANEL_W || y >= PANEL_H) return 0;
            px = x;
            py = y;
            return 1;
        endfunction

        // Column-major search for the next glyph position that produces a pixel.
        function bit glyph_seek(int c, int r, output int oc, output int orow);
            logic [7:0] px, py;
            oc = 0;
            orow = 0;
            while (c < GLYPH_COLS) begin
                while (r < GLYPH_ROWS) begin
                    if (glyph_emits(c, r, px, py)) begin
                        oc = c;
                        orow = r;
                        return 1;
                    end
                    r++;
                end
                c++;
                r = 0;
            end
            return 0;
        endfunction

        function void glyph_load(int c, int r);
            logic [7:0] px, py;
            void'(glyph_emits(c, r, px, py));
            gcol = 3'(c);
            grow = 3'(r);
            win_col_lo = px;
            win_col_hi = px;
            win_row_lo = py;
            win_row_hi = py;
            hdr_step = 0;
            low_half = 0;
            state = ST_CHAR_HDR;
        endfunction

        function void note_request(draw_req_t rq);
            panel_resp_t rs;
            logic [7:0]  x1, x2, y1, y2, t, code;
            logic [15:0] colour;
            int          c, r, nc, nr;
            rs = '0;
            if (rq.func != FUNC_PULL) begin
                if (busy()) begin
                    rs.kind = KIND_BUSY;
                    n_refused++;
                end else begin
                    rs.kind = KIND_ACCEPT;
                    n_taken++;
                    ink = rq.fore_colour;
                    x1 = rq.x_start;
                    x2 = rq.x_end;
                    y1 = flip_row(rq.y_start);
                    y2 = flip_row(rq.y_end);
                    if (rq.func == FUNC_PIXEL) begin
                        x2 = x1;
                        y2 = y1;
                    end
                    if (rq.func == FUNC_CHAR) begin
                        code = rq.char_code;
                        if (code < CHAR_FIRST || code > CHAR_LAST) code = CHAR_FIRST;
                        paper = rq.back_colour;
                        glyph_idx = 7'(code - CHAR_FIRST);
                        origin_col = rq.x_start;
                        origin_row = rq.y_start;
                        if (glyph_seek(0, 0, nc, nr)) glyph_load(nc, nr);
                        else state = ST_IDLE;
                    end else begin
                        if (x1 > x2) begin
                            t = x1; x1 = x2; x2 = t;
                        end
                        if (y1 > y2) begin
                            t = y1; y1 = y2; y2 = t;
                        end
                        // Only the low corner is checked against the panel.
                        if (x1 < PANEL_W && y1 < PANEL_H) begin
                            win_col_lo = x1;
                            win_col_hi = x2;
                            win_row_lo = y1;
                            win_row_hi = y2;
                            col_ctr = x1;
                            row_ctr = y1;
                            hdr_step = 0;
                            low_half = 0;
                            state = ST_FILL_HDR;
                        end
                    end
                end
            end else if (busy()) begin
                rs.kind = KIND_BYTE;
                n_bytes++;
                if (state == ST_FILL_HDR || state == ST_CHAR_HDR) begin
                    case (hdr_step)
                        4'd0:    rs.byte_value = CMD_CASET;
                        4'd2:    rs.byte_value = win_col_lo;
                        4'd4:    rs.byte_value = win_col_hi;
                        4'd5:    rs.byte_value = CMD_RASET;
                        4'd7:    rs.byte_value = win_row_lo;
                        4'd9:    rs.byte_value = win_row_hi;
                        4'd10:   rs.byte_value = CMD_RAMWR;
                        default: rs.byte_value = 8'h00;
                    endcase
                    rs.is_data = !(hdr_step == 0 || hdr_step == 5 || hdr_step >= 10);
                    if (hdr_step >= 10) begin
                        state = (state == ST_FILL_HDR) ? ST_FILL_DATA : ST_CHAR_DATA;
                        low_half = 0;
                    end else begin
                        hdr_step = hdr_step + 4'd1;
                    end
                end else begin
                    colour = ink;
                    if (state == ST_CHAR_DATA && !glyph_bit(int'(gcol), int'(grow))) colour = paper;
                    rs.is_data = 1;
                    rs.byte_value = low_half ? colour[7:0] : colour[15:8];
                    if (!low_half) begin
                        low_half = 1;
                    end else if (state == ST_FILL_DATA) begin
                        low_half = 0;
                        if (col_ctr >= win_col_hi) begin
                            if (row_ctr >= win_row_hi) begin
                                rs.last = 1;
                                state = ST_IDLE;
                                n_draws++;
                            end else begin
                                col_ctr = win_col_lo;
                                row_ctr = row_ctr + 8'd1;
                            end
                        end else begin
                            col_ctr = col_ctr + 8'd1;
                        end
                    end else begin
                        c = int'(gcol);
                        r = int'(grow) + 1;
                        if (r >= GLYPH_ROWS) begin
                            r = 0;
                            c++;
                        end
                        if (glyph_seek(c, r, nc, nr)) begin
                            glyph_load(nc, nr);
                        end else begin
                            rs.last = 1;
                            low_half = 0;
                            state = ST_IDLE;
                            n_draws++;
                        end
                    end
                end
            end else begin
                state = ST_IDLE;
            end
            expected_responses.push_back(rs);
        endfunction

        function void check_result(panel_resp_t got);
            panel_resp_t want;
            if (expected_responses.size() == 0) begin
                $error("result transfer with none expected: kind %0d byte_value 0x%02h",
                       got.kind, got.byte_value);
                fails++;
                return;
            end
            want = expected_responses.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                fails++;
            end
            if (got.byte_value !== want.byte_value) begin
                $error("byte_value: expected 0x%02h, got 0x%02h", want.byte_value, got.byte_value);
                fails++;
            end
            if (got.is_data !== want.is_data) begin
                $error("is_data: expected %0d, got %0d", want.is_data, got.is_data);
                fails++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                fails++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  m_tlast;

    panel_stream_scoreboard sb = new();
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_left = 0;
    int items_sent = 0;

    lcd_draw_command_sequencer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5000000;
        $display("lcd_draw_command_sequencer: mismatch");
        $finish;
    end

    // Result side: random back-pressure, plus long hold-offs on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        panel_resp_t got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.kind = m_tuser[1:0];
                got.is_data = m_tuser[2];
                got.byte_value = m_tdata;
                got.last = m_tlast;
                sb.check_result(got);
            end
        end
    end

    function automatic draw_req_t random_fields(logic [1:0] func);
        draw_req_t rq;
        rq.func = func;
        rq.x_start = 8'($urandom);
        rq.y_start = 8'($urandom);
        rq.x_end = 8'($urandom);
        rq.y_end = 8'($urandom);
        rq.fore_colour = 16'($urandom);
        rq.back_colour = 16'($urandom);
        rq.char_code = 8'($urandom);
        return rq;
    endfunction

    function automatic draw_req_t make_req(logic [1:0] func, logic [7:0] xs, logic [7:0] ys,
                                           logic [7:0] xe, logic [7:0] ye, logic [15:0] fore,
                                           logic [15:0] back, logic [7:0] code);
        draw_req_t rq;
        rq = '{func, xs, ys, xe, ye, fore, back, code};
        return rq;
    endfunction

    // Commands mostly land on the panel with small windows so that whole draws complete often.
    function automatic draw_req_t shaped_draw();
        draw_req_t rq;
        int        sel, lo, hi, span;
        rq = random_fields(FUNC_PIXEL);
        sel = $urandom_range(0, 9);
        rq.func = (sel < 4) ? FUNC_FILL : (sel < 7) ? FUNC_PIXEL : FUNC_CHAR;
        case (rq.func)
            FUNC_FILL: begin
                span = ($urandom_range(0, 19) == 0) ? 24 : 3;
                lo = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 127) : $urandom_range(128, 255);
                hi = lo + $urandom_range(0, span);
                if (hi > 255) hi = 255;
                if ($urandom_range(0, 1)) begin
                    rq.x_start = 8'(lo);
                    rq.x_end = 8'(hi);
                end else begin
                    rq.x_start = 8'(hi);
                    rq.x_end = 8'(lo);
                end
                // Rows are picked after the flip and mapped back, so the window stays small.
                span = (span == 24) ? 5 : 2;
                lo = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 159) : $urandom_range(160, 255);
                hi = lo + $urandom_range(0, span);
                if (hi > 255) hi = 255;
                if ($urandom_range(0, 1)) begin
                    rq.y_start = 8'(PANEL_H - 1 - lo);
                    rq.y_end = 8'(PANEL_H - 1 - hi);
                end else begin
                    rq.y_start = 8'(PANEL_H - 1 - hi);
                    rq.y_end = 8'(PANEL_H - 1 - lo);
                end
            end
            FUNC_PIXEL: begin
                if ($urandom_range(0, 9) != 0) rq.x_start = 8'($urandom_range(0, 127));
            end
            default: begin
                if ($urandom_range(0, 7) != 0) rq.x_start = 8'($urandom_range(0, 122));
                if ($urandom_range(0, 7) != 0) rq.y_start = 8'($urandom_range(0, 153));
                if ($urandom_range(0, 1)) rq.back_colour = rq.fore_colour;
                if ($urandom_range(0, 7) != 0) rq.char_code = 8'($urandom_range(32, 126));
            end
        endcase
        return rq;
    endfunction

    task automatic send_item(draw_req_t rq);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata <= IN_DATA_W'({$urandom, $urandom, $urandom});
            s_tuser <= IN_USER_W'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= rq.func;
        s_tdata <= {rq.char_code, rq.back_colour, rq.fore_colour,
                    rq.y_end, rq.x_end, rq.y_start, rq.x_start};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(rq);
        items_sent++;
    endtask

    task automatic draw_and_drain(draw_req_t rq);
        send_item(rq);
        while (sb.busy()) send_item(random_fields(FUNC_PULL));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic directed_checks();
        send_item(random_fields(FUNC_PULL));
        // Single row running past the right edge with the corners given high first; the high
        // column is not clipped.
        draw_and_drain(make_req(FUNC_FILL, 8'd255, 8'd159, 8'd120, 8'd159, 16'hFFFF, 16'h0000, 8'h00));
        draw_and_drain(make_req(FUNC_FILL, 8'd3, 8'd0, 8'd1, 8'd1, 16'hA55A, 16'h0000, 8'h00));
        draw_and_drain(make_req(FUNC_FILL, 8'd200, 8'd10, 8'd128, 8'd20, 16'h1111, 16'h0, 8'h0));
        draw_and_drain(make_req(FUNC_FILL, 8'd5, 8'd255, 8'd6, 8'd255, 16'h2222, 16'h0, 8'h0));
        // Row 0 flips to 159 and row 255 to 160: the window crosses the panel's bottom edge.
        draw_and_drain(make_req(FUNC_FILL, 8'd0, 8'd255, 8'd1, 8'd0, 16'h1234, 16'h0, 8'h0));
        draw_and_drain(make_req(FUNC_PIXEL, 8'd127, 8'd0, 8'd0, 8'd0, 16'h5AA5, 16'h0, 8'h0));
        draw_and_drain(make_req(FUNC_PIXEL, 8'd0, 8'd159, 8'd9, 8'd9, 16'h8001, 16'h0, 8'h0));
        draw_and_drain(make_req(FUNC_PIXEL, 8'd128, 8'd5, 8'd0, 8'd0, 16'h3333, 16'h0, 8'h0));
        draw_and_drain(make_req(FUNC_PIXEL, 8'd0, 8'd200, 8'd0, 8'd0, 16'h4444, 16'h0, 8'h0));
        // Characters at the right and top edges lose the columns and rows that fall off the panel.
        draw_and_drain(make_req(FUNC_CHAR, 8'd125, 8'd20, 8'd0, 8'd0, 16'hF800, 16'h001F, 8'h41));
        draw_and_drain(make_req(FUNC_CHAR, 8'd40, 8'd157, 8'd0, 8'd0, 16'h07E0, 16'hFFFF, 8'h7F));
        draw_and_drain(make_req(FUNC_CHAR, 8'd40, 8'd60, 8'd0, 8'd0, 16'h07E0, 16'h07E0, 8'h1F));
        draw_and_drain(make_req(FUNC_CHAR, 8'd124, 8'd3, 8'd0, 8'd0, 16'hABCD, 16'hABCD, 8'h7E));
        draw_and_drain(make_req(FUNC_CHAR, 8'd50, 8'd50, 8'd0, 8'd0, 16'h0F0F, 16'h0F0F, 8'hFF));
        draw_and_drain(make_req(FUNC_CHAR, 8'd126, 8'd254, 8'd0, 8'd0, 16'hC3C3, 16'h3C3C, 8'h23));
        // Commands arriving mid-stream must be refused without disturbing the draw.
        send_item(make_req(FUNC_FILL, 8'd4, 8'd40, 8'd6, 8'd42, 16'h0F0F, 16'hF0F0, 8'h00));
        repeat (3) send_item(random_fields(FUNC_PULL));
        send_item(random_fields(FUNC_CHAR));
        send_item(random_fields(FUNC_PIXEL));
        draw_and_drain(random_fields(FUNC_FILL));
        send_item(random_fields(FUNC_PULL));
    endtask

    task automatic random_traffic(int n);
        int stop;
        stop = items_sent + n;
        while (items_sent < stop) begin
            if (sb.busy()) begin
                if ($urandom_range(0, 24) == 0) send_item(random_fields(2'($urandom_range(1, 3))));
                else send_item(random_fields(FUNC_PULL));
            end else if ($urandom_range(0, 15) == 0) begin
                send_item(random_fields(FUNC_PULL));
            end else begin
                send_item(shaped_draw());
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 25;
        rx_idle_pct = 62;
        directed_checks();
        wait_drained();
        random_traffic(180);
        wait_drained();

        tx_idle_pct = 62;
        rx_idle_pct = 25;
        random_traffic(180);
        wait_drained();

        // No idling here; a long receiver hold-off backs the pipeline up into the input.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_left = 300;
        random_traffic(180);
        wait_drained();
        repeat (20) @(posedge aclk);

        $display("Run covered %0d input transfers: %0d draw commands taken, %0d refused as busy.",
                 items_sent, sb.n_taken, sb.n_refused);
        $display("Checked %0d panel stream bytes over %0d completed draws.",
                 sb.n_bytes, sb.n_draws);
        if (sb.fails == 0) begin
            $display("lcd_draw_command_sequencer: match");
        end else begin
            $display("lcd_draw_command_sequencer: mismatch");
        end
        $finish;
    end

endmodule

@@ lcd_draw_command_sequencer.f @@
rtl/lcdseq_pkg.sv
rtl/lcd_draw_command_sequencer.sv
rtl/lcdseq_checker.sv
tb/lcd_draw_command_sequencer_tb.sv
